// ===== hdl/nmvp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nmvp_pkg: shared types and constants
// Field widths, opcodes, output saturation limits and sequencer states for
// the normalized matrix-vector product.
// ----------------------------------------------------------------------------
package nmvp_pkg;

	localparam int OPCODE_W = 2;
	localparam int INDEX_W  = 6;
	localparam int ELEM_W   = 16;
	localparam int OUT_W    = 24;
	localparam int SIZE_W   = 7;
	localparam int FRAC_OUT = 16;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

	localparam logic [OPCODE_W-1:0] OP_LOAD_VEC = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_LOAD_MAT = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_COMPUTE  = 2'd2;

	localparam logic [OUT_W-1:0] SAT_HI = 24'h7FFFFF;
	localparam logic [OUT_W-1:0] SAT_LO = 24'h800000;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_MAC   = 6'b000010,
		S_FETCH = 6'b000100,
		S_LOAD  = 6'b001000,
		S_DIV   = 6'b010000,
		S_PUT   = 6'b100000
	} state_t;

endpackage
`default_nettype wire

// ===== hdl/normalized_matrix_vector_product.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// normalized_matrix_vector_product: normalized dense matrix-vector product
// Loads a square matrix and a vector one element per transfer, then on a
// compute command forms every row's dot product, their total, and emits each
// row result divided by the total as signed Q8.16 with saturation.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  cfg     | in        | cfg_valid/cfg_ready  | cfg_data (size_in_use)
//  in      | in        | in_valid/in_ready    | opcode, row_index, col_index,
//          |           |                      | element_value
//  out     | out       | out_valid/out_ready  | out_row, normalized_value,
//          |           |                      | last_row, zero_total
//
//  Loads are taken back to back; in_ready stays high between commands.
//  A compute command of size n holds in_ready low through multiply-accumulate
//  (one product per cycle through the single multiplier, matrix and vector
//  RAM reads registered), then through the division of each of the n row
//  sums, RW = 32 + log2(MAX_N) bits wide, by the shared one-bit-per-cycle
//  restoring divider.
//  A stalled output holds the sequencer on its row; the last result may wait
//  in the output register while new loads are taken.
//  Reset clears control state and sets size_in_use to 64; RAMs need no clear.
//
module normalized_matrix_vector_product #(
	parameter int MAX_N = 64
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// configuration
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [nmvp_pkg::SIZE_W-1:0]           cfg_data,
	// command / load input
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic [nmvp_pkg::OPCODE_W-1:0]         opcode,
	input  wire logic [nmvp_pkg::INDEX_W-1:0]          row_index,
	input  wire logic [nmvp_pkg::INDEX_W-1:0]          col_index,
	input  wire logic signed [nmvp_pkg::ELEM_W-1:0]    element_value,
	// result output
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic [nmvp_pkg::INDEX_W-1:0]               out_row,
	output logic signed [nmvp_pkg::OUT_W-1:0]          normalized_value,
	output logic                                       last_row,
	output logic                                       zero_total
);
	import nmvp_pkg::*;

	localparam int AW        = $clog2(MAX_N);
	localparam int CW        = $clog2(MAX_N + 1);
	localparam int NW        = (CW > SIZE_W) ? CW : SIZE_W;
	localparam int RW        = 2 * ELEM_W + AW;      // exact row sum
	localparam int TW        = 2 * ELEM_W + 2 * AW;  // exact total
	localparam int MAT_DEPTH = MAX_N * (2 ** AW);

	state_t state_q;

	logic [SIZE_W-1:0] size_q;

	// sequencer counters
	logic [AW-1:0] i_q;
	logic [AW-1:0] j_q;
	logic [AW-1:0] k_q;
	logic [AW-1:0] nm1_q;
	logic          issue_q;

	// multiply-accumulate pipeline
	logic          v_s1, first_s1, last_s1, final_s1;
	logic [AW-1:0] row_s1;
	logic          v_s2, first_s2, last_s2, final_s2;
	logic [AW-1:0] row_s2;
	logic signed [2*ELEM_W-1:0] prod_s2;
	logic          v_s3, final_s3;
	logic [AW-1:0] row_s3;
	logic signed [RW-1:0] acc_q;
	logic signed [TW-1:0] total_q;

	// output register
	logic                    out_valid_q;
	logic [INDEX_W-1:0]      out_row_q;
	logic signed [OUT_W-1:0] out_value_q;
	logic                    out_last_q;
	logic                    out_zero_q;

	// RAM ports
	logic            vec_we;
	logic [AW-1:0]   vec_waddr;
	logic [ELEM_W-1:0] vec_rdata;
	logic            mat_we;
	logic [2*AW-1:0] mat_waddr;
	logic [2*AW-1:0] mat_raddr;
	logic [ELEM_W-1:0] mat_rdata;
	logic [RW-1:0]   rr_rdata;

	// divider
	logic                    div_start;
	logic                    div_done;
	logic signed [OUT_W-1:0] div_quot;

	// misc decode
	logic            in_xfer;
	logic            compute_go;
	logic            out_free;
	logic            put_fire;
	logic            total_zero;
	logic [NW-1:0]   size_ext;
	logic [NW-1:0]   n_eff;
	logic [AW-1:0]   nm1_d;
	logic signed [RW-1:0] acc_base;
	logic signed [RW-1:0] acc_sum;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_xfer   = in_valid && in_ready;

	// Drop loads whose index falls outside the store.
	assign vec_we    = in_xfer && (opcode == OP_LOAD_VEC) && (int'(col_index) < MAX_N);
	assign mat_we    = in_xfer && (opcode == OP_LOAD_MAT) && (int'(col_index) < MAX_N)
	                   && (int'(row_index) < MAX_N);
	assign vec_waddr = AW'(col_index);
	assign mat_waddr = {AW'(row_index), AW'(col_index)};
	assign mat_raddr = {i_q, j_q};

	// Clamp the size to MAX_N; a zero size makes compute a no-op.
	always_comb begin
		size_ext = NW'(size_q);
		n_eff    = (size_ext > NW'(MAX_N)) ? NW'(MAX_N) : size_ext;
		nm1_d    = AW'(n_eff - NW'(1));
	end
	assign compute_go = in_xfer && (opcode == OP_COMPUTE) && (size_q != '0);

	assign out_free   = !out_valid_q || out_ready;
	assign put_fire   = (state_q == S_PUT) && out_free;
	assign div_start  = (state_q == S_LOAD);
	assign total_zero = (total_q == '0);

	always_comb begin
		acc_base = first_s2 ? RW'(0) : acc_q;
		acc_sum  = acc_base + RW'(prod_s2);
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			size_q <= cfg_data;
		end
	end

	// Sequencer and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			nm1_q       <= '0;
			issue_q     <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// pipeline valids advance every cycle
			v_s1 <= issue_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && last_s2;

			if (put_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (compute_go) begin
						state_q <= S_MAC;
						i_q     <= '0;
						j_q     <= '0;
						nm1_q   <= nm1_d;
						issue_q <= 1'b1;
					end
				end
				S_MAC: begin
					// walk the matrix row by row, one element a cycle
					if (issue_q) begin
						if (j_q == nm1_q) begin
							j_q <= '0;
							if (i_q == nm1_q) begin
								issue_q <= 1'b0;
							end else begin
								i_q <= i_q + AW'(1);
							end
						end else begin
							j_q <= j_q + AW'(1);
						end
					end
					if (v_s3 && final_s3) begin
						state_q <= S_FETCH;
						k_q     <= '0;
					end
				end
				S_FETCH: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					if (out_free) begin
						if (k_q == nm1_q) begin
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + AW'(1);
							state_q <= S_FETCH;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		// stage 1: RAM read issued, tag the element
		first_s1 <= (j_q == '0);
		last_s1  <= (j_q == nm1_q);
		final_s1 <= (j_q == nm1_q) && (i_q == nm1_q);
		row_s1   <= i_q;

		// stage 2: multiply
		prod_s2  <= $signed(mat_rdata) * $signed(vec_rdata);
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		final_s2 <= final_s1;
		row_s2   <= row_s1;

		// stage 3: row sum complete, fold into total
		final_s3 <= final_s2;
		row_s3   <= row_s2;

		if (v_s2) begin
			acc_q <= acc_sum;
		end

		if (compute_go) begin
			total_q <= '0;
		end else if (v_s3) begin
			total_q <= total_q + TW'(acc_q);
		end

		if (put_fire) begin
			out_row_q   <= INDEX_W'(k_q);
			out_value_q <= total_zero ? OUT_W'(0) : div_quot;
			out_last_q  <= (k_q == nm1_q);
			out_zero_q  <= total_zero;
		end
	end

	assign out_valid        = out_valid_q;
	assign out_row          = out_row_q;
	assign normalized_value = out_value_q;
	assign last_row         = out_last_q;
	assign zero_total       = out_zero_q;

	nmvp_ram #(
		.WIDTH (ELEM_W),
		.DEPTH (MAX_N)
	) u_vec_ram (
		.clk     (clk),
		.wr_en   (vec_we),
		.wr_addr (vec_waddr),
		.wr_data (element_value),
		.rd_addr (j_q),
		.rd_data (vec_rdata)
	);

	nmvp_ram #(
		.WIDTH (ELEM_W),
		.DEPTH (MAT_DEPTH)
	) u_mat_ram (
		.clk     (clk),
		.wr_en   (mat_we),
		.wr_addr (mat_waddr),
		.wr_data (element_value),
		.rd_addr (mat_raddr),
		.rd_data (mat_rdata)
	);

	nmvp_ram #(
		.WIDTH (RW),
		.DEPTH (MAX_N)
	) u_row_ram (
		.clk     (clk),
		.wr_en   (v_s3),
		.wr_addr (row_s3),
		.wr_data (acc_q),
		.rd_addr (k_q),
		.rd_data (rr_rdata)
	);

	nmvp_div #(
		.RW (RW),
		.TW (TW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rr_rdata),
		.divisor  (total_q),
		.done     (div_done),
		.quotient (div_quot)
	);

endmodule
`default_nettype wire

// ===== hdl/nmvp_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nmvp_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module nmvp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

// ===== hdl/nmvp_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nmvp_div: radix-2 restoring divider with output saturation
// Computes (dividend * 2^16) / divisor, truncated toward zero, one quotient
// bit per cycle, then saturates the result to signed 24 bits.
// ----------------------------------------------------------------------------
module nmvp_div #(
	parameter int RW = 38,
	parameter int TW = 44
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic signed [RW-1:0]                dividend,
	input  wire logic signed [TW-1:0]                divisor,
	output logic                                     done,
	output logic signed [nmvp_pkg::OUT_W-1:0]        quotient
);
	import nmvp_pkg::*;

	localparam int DW   = RW + FRAC_OUT;
	localparam int CNTW = $clog2(DW + 1);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [TW-1:0]   rem_q;
	logic [TW-1:0]   den_q;
	logic [DW-1:0]   quo_q;
	logic            neg_q;

	logic [RW-1:0] abs_num;
	logic [TW-1:0] abs_den;
	logic [TW:0]   trial;
	logic [TW:0]   diff;
	logic          ge;
	logic [TW-1:0] rem_next;
	logic          neg_sat;
	logic          pos_sat;

	always_comb begin
		abs_num  = dividend[RW-1] ? RW'(-dividend) : RW'(dividend);
		abs_den  = divisor[TW-1] ? TW'(-divisor) : TW'(divisor);
		trial    = {rem_q, quo_q[DW-1]};
		ge       = trial >= {1'b0, den_q};
		diff     = trial - {1'b0, den_q};
		rem_next = ge ? diff[TW-1:0] : trial[TW-1:0];
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift the dividend out and the quotient in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= {abs_num, FRAC_OUT'(0)};
			den_q <= abs_den;
			neg_q <= dividend[RW-1] ^ divisor[TW-1];
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	always_comb begin
		neg_sat = (|quo_q[DW-1:OUT_W]) || (quo_q[OUT_W-1] && (|quo_q[OUT_W-2:0]));
		pos_sat = |quo_q[DW-1:OUT_W-1];
		if (neg_q) begin
			quotient = neg_sat ? SAT_LO : -quo_q[OUT_W-1:0];
		end else begin
			quotient = pos_sat ? SAT_HI : quo_q[OUT_W-1:0];
		end
	end

	assign done = done_q;

endmodule
`default_nettype wire

// ===== hdl/nmvp_chk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nmvp_chk: port-level checker
// Watches the top-level ports of the normalized matrix-vector product.
// ----------------------------------------------------------------------------
module nmvp_chk (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 in_valid,
	input wire logic                                 in_ready,
	input wire logic [nmvp_pkg::OPCODE_W-1:0]        opcode,
	input wire logic                                 out_valid,
	input wire logic                                 out_ready,
	input wire logic [nmvp_pkg::INDEX_W-1:0]         out_row,
	input wire logic signed [nmvp_pkg::OUT_W-1:0]    normalized_value,
	input wire logic                                 last_row,
	input wire logic                                 zero_total
);
	import nmvp_pkg::*;

	// Hold a stalled result steady.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_row)
			&& $stable(normalized_value) && $stable(last_row) && $stable(zero_total))
		else $error("stalled result changed");

	// A zero total forces a zero quotient.
	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_total |-> normalized_value == '0)
		else $error("nonzero result with zero total");

	// While idle with nothing pending, no result appears.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && !out_valid |=> !out_valid)
		else $error("result appeared without a compute");

	// A compute transfer is never followed at once by a new result.
	a_compute_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && opcode == OP_COMPUTE |=> !$rose(out_valid))
		else $error("result too soon after compute");

endmodule

bind normalized_matrix_vector_product nmvp_chk u_nmvp_chk (.*);
`default_nettype wire
